@@ src/riec_pkg.sv @@
// Shared constants, types and helper functions for the recent item expiry cache.
package riec_pkg;

	localparam int ENTRIES = 128;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam int PFX_W   = 64;
	localparam int VER_W   = 64;
	localparam int TIME_W  = 32;
	localparam int EXP_W   = 33;
	localparam int TMO_W   = 16;
	localparam int SLOT_W  = 7;
	localparam int VICT_W  = 7;

	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [TMO_W-1:0] TMO_RESET = 16'd240;

	localparam logic CMD_REMEMBER = 1'b0;
	localparam logic CMD_QUERY    = 1'b1;

	// register index taken from paddr[2]
	localparam logic REG_TIMEOUT = 1'b0;

	// width of the reduction register used by victim_mod
	localparam int RED_W = IDX_W + VICT_W + 1;

	typedef struct packed {
		logic [PFX_W-1:0] pfx;
		logic [VER_W-1:0] ver;
		logic [EXP_W-1:0] exp;
	} entry_t;

	// two's complement a >= b
	function automatic logic ver_ge(input logic [VER_W-1:0] a, input logic [VER_W-1:0] b);
		return $signed(a) >= $signed(b);
	endfunction

	// victim index modulo ENTRIES by restoring compare and subtract
	function automatic logic [IDX_W-1:0] victim_mod(input logic [VICT_W-1:0] v);
		logic [RED_W-1:0] r;
		logic [RED_W-1:0] d;
		r = RED_W'(v);
		for (int b = VICT_W - 1; b >= 0; b--) begin
			d = RED_W'(ENTRIES) << b;
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[IDX_W-1:0];
	endfunction

endpackage

@@ src/riec_core.sv @@
// Scan engine and entry memory: lookup, renew, append and replacement.
module riec_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          command,
	input  logic [riec_pkg::PFX_W-1:0]    item_prefix,
	input  logic [riec_pkg::VER_W-1:0]    item_version,
	input  logic [riec_pkg::TIME_W-1:0]   current_time,
	input  logic [riec_pkg::VICT_W-1:0]   victim_index,
	input  logic [riec_pkg::TMO_W-1:0]    timeout_seconds,
	output logic                          busy,
	output logic                          done,
	output logic                          recent,
	output logic                          matched,
	output logic [riec_pkg::SLOT_W-1:0]   slot_used
);
	import riec_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t state_q;

	entry_t mem [ENTRIES];
	entry_t rdat_s1;
	logic   rv_s1;
	logic [IDX_W-1:0] ri_s1;

	logic [CNT_W-1:0] ra_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] filled_q;

	logic              cmd_q;
	logic [PFX_W-1:0]  pfx_q;
	logic [VER_W-1:0]  ver_q;
	logic [TIME_W-1:0] now_q;
	logic [VICT_W-1:0] vict_q;
	logic [EXP_W-1:0]  nexp_q;

	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [VER_W-1:0]  hit_ver_q;
	logic [EXP_W-1:0]  hit_exp_q;
	logic              hexp_q;
	logic [IDX_W-1:0]  lexp_q;

	logic              done_q;
	logic              recent_q;
	logic              matched_q;
	logic [SLOT_W-1:0] slot_q;

	logic              accept;
	logic              issue;
	logic              hit_now;
	logic              scan_end;
	logic              expired_now;
	logic              full;
	logic [IDX_W-1:0]  slot;
	logic              wr_en;
	entry_t            wr_data;
	logic              fin_recent;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign hit_now     = (state_q == S_SCAN) && rv_s1 && (rdat_s1.pfx == pfx_q);
	assign issue       = (state_q == S_SCAN) && !hit_now && (ra_q < cnt_q);
	assign scan_end    = (state_q == S_SCAN) && !rv_s1 && (ra_q == cnt_q);
	assign expired_now = (state_q == S_SCAN) && rv_s1 && !hit_now
	                     && (rdat_s1.exp < EXP_W'(now_q));

	assign full = (cnt_q == CNT_W'(ENTRIES));

	always_comb begin
		if (hit_q) begin
			slot = hit_idx_q;
		end else if (full) begin
			slot = hexp_q ? lexp_q : victim_mod(vict_q);
		end else begin
			slot = cnt_q[IDX_W-1:0];
		end
	end

	assign wr_en       = (state_q == S_FIN) && (cmd_q == CMD_REMEMBER);
	assign wr_data.pfx = pfx_q;
	// an older version renews the expiry but keeps the stored version
	assign wr_data.ver = (hit_q && !ver_ge(ver_q, hit_ver_q)) ? hit_ver_q : ver_q;
	assign wr_data.exp = nexp_q;

	assign fin_recent = (cmd_q == CMD_QUERY) && hit_q && ver_ge(hit_ver_q, ver_q)
	                    && (hit_exp_q >= EXP_W'(now_q));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[slot] <= wr_data;
		end
		if (issue) begin
			rdat_s1 <= mem[ra_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rv_s1    <= 1'b0;
			ra_q     <= '0;
			cnt_q    <= '0;
			filled_q <= '0;
			hit_q    <= 1'b0;
			hexp_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= (state_q == S_FIN);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						ra_q    <= '0;
						rv_s1   <= 1'b0;
						hit_q   <= 1'b0;
						hexp_q  <= 1'b0;
						cnt_q   <= filled_q;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rv_s1 <= issue;
					if (issue) begin
						ra_q <= ra_q + 1'b1;
					end
					if (expired_now) begin
						hexp_q <= 1'b1;
					end
					if (hit_now) begin
						hit_q   <= 1'b1;
						state_q <= S_FIN;
					end else if (scan_end) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (cmd_q == CMD_REMEMBER && !hit_q && !full) begin
						filled_q <= filled_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			pfx_q  <= item_prefix;
			ver_q  <= item_version;
			now_q  <= current_time;
			vict_q <= victim_index;
			nexp_q <= EXP_W'(current_time) + EXP_W'(timeout_seconds);
		end
		if (state_q == S_SCAN) begin
			ri_s1 <= ra_q[IDX_W-1:0];
		end
		if (hit_now) begin
			hit_idx_q <= ri_s1;
			hit_ver_q <= rdat_s1.ver;
			hit_exp_q <= rdat_s1.exp;
		end
		if (expired_now) begin
			lexp_q <= ri_s1;
		end
		if (state_q == S_FIN) begin
			recent_q  <= fin_recent;
			matched_q <= hit_q;
			slot_q    <= (cmd_q == CMD_QUERY && !hit_q) ? '0 : SLOT_W'(slot);
		end
	end

	assign done      = done_q;
	assign recent    = recent_q;
	assign matched   = matched_q;
	assign slot_used = slot_q;

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not start a scan");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= CNT_W'(ENTRIES))
		else $error("fill count beyond capacity");

	a_recent_match: assert property (@(posedge clk) disable iff (!arst_n)
		(done && recent) |-> matched)
		else $error("recent reported without a match");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> done)
		else $error("finish step without result strobe");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (ra_q <= cnt_q))
		else $error("scan address ran past the fill count");
`endif

endmodule

@@ src/recent_item_expiry_cache_top.sv @@
// Top level: APB timeout register and the scan engine of the recent item expiry cache.
// Scan: on a miss every filled entry is read, on a hit the scan stops at the matching entry;
//   one entry is read per cycle from the entry memory port while scanning.
// One item is handled at a time.
// Results are strobed for one cycle and cannot be stalled.
// Reset: fill count cleared, timeout back to 240 s; entry memory is not cleared.
module recent_item_expiry_cache_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          command,
	input  logic [riec_pkg::PFX_W-1:0]    item_prefix,
	input  logic [riec_pkg::VER_W-1:0]    item_version,
	input  logic [riec_pkg::TIME_W-1:0]   current_time,
	input  logic [riec_pkg::VICT_W-1:0]   victim_index,
	output logic                          done,
	output logic                          recent,
	output logic                          matched,
	output logic [riec_pkg::SLOT_W-1:0]   slot_used,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [riec_pkg::ADDR_W-1:0]   paddr,
	input  logic [riec_pkg::DATA_W-1:0]   pwdata,
	output logic [riec_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import riec_pkg::*;

	logic [TMO_W-1:0] timeout_q;
	logic             reg_wr;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TMO_RESET;
		end else if (reg_wr && paddr[2] == REG_TIMEOUT) begin
			timeout_q <= pwdata[TMO_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_TIMEOUT) ? DATA_W'(timeout_q) : '0;

	riec_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.command         (command),
		.item_prefix     (item_prefix),
		.item_version    (item_version),
		.current_time    (current_time),
		.victim_index    (victim_index),
		.timeout_seconds (timeout_q),
		.busy            (busy),
		.done            (done),
		.recent          (recent),
		.matched         (matched),
		.slot_used       (slot_used)
	);

endmodule
